>>> rtl/ngga_pkg.sv
// Constants and helper functions shared by the GGA position parser.
`timescale 1ns / 1ps

package ngga_pkg;

	localparam int unsigned MAX_LINE_CHARS = 99;
	localparam int unsigned FRACTION_DIGITS = 5;

	localparam int unsigned ACC_W = 34;
	localparam int unsigned POS_W = 35;
	localparam int unsigned LEN_W = $clog2(MAX_LINE_CHARS + 1);
	localparam int unsigned FIELD_W = 4;
	localparam int unsigned FIELD_MAX = 15;
	localparam int unsigned FRAC_W = $clog2(FRACTION_DIGITS + 1);
	localparam int unsigned PREFIX_W = 3;
	localparam int unsigned PREFIX_LEN = 6;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_A = 8'h41;

	function automatic longint unsigned ten_pow(input int unsigned k);
		longint unsigned v;
		v = 1;
		for (int unsigned i = 0; i < k; i++) begin
			v = v * 10;
		end
		return v;
	endfunction

	localparam longint unsigned ACC_MAX = (64'd1 << ACC_W) - 64'd1;
	localparam longint unsigned POS_MAX = (64'd1 << ACC_W) - 64'd1;
	localparam int unsigned PAD_W = $clog2(ten_pow(FRACTION_DIGITS) + 1);

	// Degrees split: value / (100 * 10^F), done by a reciprocal multiply.
	localparam longint unsigned UNIT = 100 * ten_pow(FRACTION_DIGITS);
	localparam int unsigned UNIT_W = $clog2(UNIT + 1);
	localparam longint unsigned R1 = (64'd1 << ACC_W) / UNIT;
	localparam int unsigned R1_W = $clog2(R1 + 1);
	localparam int unsigned DEG_W = $clog2(ACC_MAX / UNIT + 1);
	localparam int unsigned REM_W = $clog2(2 * UNIT);

	// Minutes to degrees: minutes * 10^(7-F) / 60.
	localparam longint unsigned E7 = 10000000;
	localparam int unsigned E7_W = $clog2(E7 + 1);
	localparam longint unsigned SCALE = ten_pow(7 - FRACTION_DIGITS);
	localparam int unsigned SCALE_W = $clog2(SCALE + 1);
	localparam int unsigned Y_W = $clog2(UNIT * SCALE);
	localparam longint unsigned MIN_DIV = 60;
	localparam int unsigned MIN_DIV_W = $clog2(MIN_DIV + 1);
	localparam longint unsigned R2 = (64'd1 << Y_W) / MIN_DIV;
	localparam int unsigned R2_W = $clog2(R2 + 1);
	localparam int unsigned T_W = $clog2((UNIT * SCALE) / MIN_DIV + 2);
	localparam int unsigned REM2_W = $clog2(2 * MIN_DIV);
	localparam int unsigned SUM_W = $clog2((ACC_MAX / UNIT) * E7 + (UNIT * SCALE) / MIN_DIV + 1);

	localparam int unsigned CONV_LAT = 8;

	function automatic logic [7:0] gga_tag(input logic [PREFIX_W-1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = CH_DOLLAR;
			3'd1: ch = CH_G;
			3'd2: ch = CH_P;
			3'd3: ch = CH_G;
			3'd4: ch = CH_G;
			3'd5: ch = CH_A;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	// Factor that scales a number with cnt fraction digits to FRACTION_DIGITS.
	function automatic logic [PAD_W-1:0] pad_factor(input logic [FRAC_W-1:0] cnt);
		logic [PAD_W-1:0] v;
		v = PAD_W'(1);
		for (int unsigned i = 0; i < FRACTION_DIGITS; i++) begin
			if (FRAC_W'(i) >= cnt) begin
				v = PAD_W'(v * PAD_W'(10));
			end
		end
		return v;
	endfunction

endpackage

>>> rtl/ngga_to_e7.sv
// Pipelined conversion of a ddmm.mmmmm accumulator to signed degrees times 10^7.
`timescale 1ns / 1ps

module ngga_to_e7 (
	input  logic                                clk,
	input  logic                                en,
	input  logic [ngga_pkg::ACC_W-1:0]          x,
	input  logic                                neg,
	output logic signed [ngga_pkg::POS_W-1:0]   e7
);
	import ngga_pkg::*;

	localparam logic [R1_W-1:0] R1_C = R1_W'(R1);
	localparam logic [UNIT_W-1:0] UNIT_C = UNIT_W'(UNIT);
	localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(SCALE);
	localparam logic [E7_W-1:0] E7_C = E7_W'(E7);
	localparam logic [R2_W-1:0] R2_C = R2_W'(R2);
	localparam logic [MIN_DIV_W-1:0] DIV_C = MIN_DIV_W'(MIN_DIV);

	logic [ACC_W-1:0]   x_s1, x_s2;
	logic [DEG_W-1:0]   q0_s2, q0_s3, q_s4;
	logic [REM_W-1:0]   r0_s3, r_s4;
	logic [Y_W-1:0]     y_s5, y_s6;
	logic [SUM_W-1:0]   deg_s5, deg_s6, deg_s7, sum_s8;
	logic [T_W-1:0]     t0_s6, t0_s7;
	logic [REM2_W-1:0]  rem_s7;
	logic [CONV_LAT-1:0] neg_q;

	logic [ACC_W+R1_W-1:0]     p1;
	logic [ACC_W-1:0]          qu;
	logic [Y_W+R2_W-1:0]       p2;
	logic [Y_W-1:0]            t60;
	logic [63:0]               sum64;
	logic [ACC_W-1:0]          mag;

	assign p1 = x_s1 * R1_C;
	assign qu = ACC_W'(q0_s2 * UNIT_C);
	assign p2 = y_s5 * R2_C;
	assign t60 = Y_W'(t0_s6 * DIV_C);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			q0_s2 <= DEG_W'(p1 >> ACC_W);
			x_s2 <= x_s1;
			r0_s3 <= REM_W'(x_s2 - qu);
			q0_s3 <= q0_s2;
			if (r0_s3 >= REM_W'(UNIT)) begin
				q_s4 <= DEG_W'(q0_s3 + 1'b1);
				r_s4 <= REM_W'(r0_s3 - REM_W'(UNIT));
			end else begin
				q_s4 <= q0_s3;
				r_s4 <= r0_s3;
			end
			y_s5 <= Y_W'(r_s4 * SCALE_C);
			deg_s5 <= SUM_W'(q_s4 * E7_C);
			t0_s6 <= T_W'(p2 >> Y_W);
			y_s6 <= y_s5;
			deg_s6 <= deg_s5;
			rem_s7 <= REM2_W'(y_s6 - t60);
			t0_s7 <= t0_s6;
			deg_s7 <= deg_s6;
			sum_s8 <= SUM_W'(deg_s7 + SUM_W'(t0_s7) +
				SUM_W'(rem_s7 >= REM2_W'(MIN_DIV)));
			neg_q <= {neg_q[CONV_LAT-2:0], neg};
		end
	end

	always_comb begin
		sum64 = 64'(sum_s8);
		mag = (sum64 > POS_MAX) ? ACC_W'(POS_MAX) : sum64[ACC_W-1:0];
		e7 = neg_q[CONV_LAT-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

>>> rtl/nmea_gga_position_parser.sv
// Top level: GGA sentence parser that turns received bytes into a position fix.
`timescale 1ns / 1ps

//  channel   handshake                fields
//  input     in_valid / in_stall      rx_byte
//  output    out_valid / out_stall    fix_valid, latitude_e7, longitude_e7
//
// One byte is accepted per cycle through a registered input stage, unless in_stall holds it.
// A result passes through the eight-stage degrees conversion pipeline and the
// position register before out_valid is raised.
// Reset clears the line state and the stored position to zero.
// While a result waits, bytes keep flowing; only a line feed that needs a
// conversion slot waits in the input stage.

module nmea_gga_position_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                fix_valid,
	output logic signed [ngga_pkg::POS_W-1:0]   latitude_e7,
	output logic signed [ngga_pkg::POS_W-1:0]   longitude_e7
);
	import ngga_pkg::*;

	logic [7:0]          byte_s1;
	logic                bvalid_s1;

	logic [PREFIX_W-1:0] prefix_q, prefix_d;
	logic                failed_q, failed_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [FIELD_W-1:0]  field_q, field_d;
	logic [ACC_W-1:0]    lat_q, lat_d, lon_q, lon_d;
	logic [FRAC_W-1:0]   frac_q, frac_d;
	logic                point_q, point_d, ended_q, ended_d;
	logic [3:0]          nz_q, nz_d;
	logic                south_q, south_d, west_q, west_d;
	logic [1:0]          dir_q, dir_d;

	logic                adv, is_lf, emit, need_slot, consume, step, launch, in_acc;
	logic                is_digit, hit;
	logic [ACC_W-1:0]    acc_src, pad_val, push_val, x_lat, x_lon;
	logic [ACC_W+PAD_W-1:0] pad_prod;
	logic [ACC_W+3:0]    push_sum;
	logic [1:0]          nz_idx;

	logic [CONV_LAT-1:0] conv_vld_q, conv_ok_q;
	logic signed [POS_W-1:0] lat_e7, lon_e7;
	logic                out_valid_q, stored_valid_q;
	logic signed [POS_W-1:0] stored_lat_q, stored_lon_q;

	assign adv = !out_valid_q || !out_stall;
	assign is_lf = (byte_s1 == CH_LF);
	assign emit = (prefix_q == PREFIX_W'(PREFIX_LEN)) && !failed_q;
	assign need_slot = is_lf && emit;
	assign consume = !need_slot || adv;
	assign step = bvalid_s1 && consume;
	assign launch = step && need_slot;
	assign in_stall = bvalid_s1 && !consume;
	assign in_acc = in_valid && !in_stall;

	assign acc_src = (field_q == FIELD_W'(4)) ? lon_q : lat_q;
	assign pad_prod = acc_src * pad_factor(frac_q);
	assign pad_val = (pad_prod[ACC_W+PAD_W-1:ACC_W] != '0) ? ACC_W'(ACC_MAX)
		: pad_prod[ACC_W-1:0];
	assign push_sum = ({4'b0, acc_src} << 3) + ({4'b0, acc_src} << 1)
		+ (ACC_W+4)'(byte_s1[3:0]);
	assign push_val = (push_sum[ACC_W+3:ACC_W] != '0) ? ACC_W'(ACC_MAX)
		: push_sum[ACC_W-1:0];
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign nz_idx = field_q[1:0] - 2'd2;
	assign x_lat = (field_q == FIELD_W'(2)) ? pad_val : lat_q;
	assign x_lon = (field_q == FIELD_W'(4)) ? pad_val : lon_q;

	always_comb begin
		prefix_d = prefix_q;
		failed_d = failed_q;
		len_d = len_q;
		field_d = field_q;
		lat_d = lat_q;
		lon_d = lon_q;
		frac_d = frac_q;
		point_d = point_q;
		ended_d = ended_q;
		nz_d = nz_q;
		south_d = south_q;
		west_d = west_q;
		dir_d = dir_q;
		hit = 1'b0;
		if (step) begin
			if (is_lf) begin
				prefix_d = '0;
				failed_d = 1'b0;
				len_d = '0;
				field_d = '0;
				lat_d = '0;
				lon_d = '0;
				frac_d = '0;
				point_d = 1'b0;
				ended_d = 1'b0;
				nz_d = '0;
				south_d = 1'b0;
				west_d = 1'b0;
				dir_d = '0;
			end else if (byte_s1 != CH_CR && len_q < LEN_W'(MAX_LINE_CHARS)) begin
				if (!failed_q && prefix_q < PREFIX_W'(PREFIX_LEN)) begin
					if (byte_s1 == gga_tag(prefix_q)) begin
						prefix_d = prefix_q + 1'b1;
					end else begin
						failed_d = 1'b1;
					end
				end
				if (byte_s1 == CH_NUL) begin
					len_d = LEN_W'(MAX_LINE_CHARS);
				end else begin
					len_d = len_q + 1'b1;
					if (byte_s1 == CH_COMMA) begin
						if (field_q == FIELD_W'(2)) begin
							lat_d = pad_val;
						end
						if (field_q == FIELD_W'(4)) begin
							lon_d = pad_val;
						end
						if (field_q < FIELD_W'(FIELD_MAX)) begin
							field_d = field_q + 1'b1;
						end
						frac_d = '0;
						point_d = 1'b0;
						ended_d = 1'b0;
						dir_d = '0;
					end else begin
						if (field_q >= FIELD_W'(2) && field_q <= FIELD_W'(5)) begin
							nz_d[nz_idx] = 1'b1;
						end
						if ((field_q == FIELD_W'(2) || field_q == FIELD_W'(4)) && !ended_q) begin
							if (is_digit) begin
								if (!point_q || frac_q < FRAC_W'(FRACTION_DIGITS)) begin
									if (field_q == FIELD_W'(4)) begin
										lon_d = push_val;
									end else begin
										lat_d = push_val;
									end
									if (point_q) begin
										frac_d = frac_q + 1'b1;
									end
								end
							end else if (byte_s1 == CH_POINT && !point_q) begin
								point_d = 1'b1;
							end else begin
								ended_d = 1'b1;
							end
						end
						if (field_q == FIELD_W'(3) || field_q == FIELD_W'(5)) begin
							hit = (dir_q == 2'd0) &&
								(byte_s1 == ((field_q == FIELD_W'(5)) ? CH_W : CH_S));
							if (field_q == FIELD_W'(3)) begin
								south_d = hit;
							end else begin
								west_d = hit;
							end
							if (dir_q < 2'd2) begin
								dir_d = dir_q + 1'b1;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_s1 <= 1'b0;
			prefix_q <= '0;
			failed_q <= 1'b0;
			len_q <= '0;
			field_q <= '0;
			lat_q <= '0;
			lon_q <= '0;
			frac_q <= '0;
			point_q <= 1'b0;
			ended_q <= 1'b0;
			nz_q <= '0;
			south_q <= 1'b0;
			west_q <= 1'b0;
			dir_q <= '0;
		end else begin
			if (in_acc) begin
				bvalid_s1 <= 1'b1;
			end else if (step) begin
				bvalid_s1 <= 1'b0;
			end
			prefix_q <= prefix_d;
			failed_q <= failed_d;
			len_q <= len_d;
			field_q <= field_d;
			lat_q <= lat_d;
			lon_q <= lon_d;
			frac_q <= frac_d;
			point_q <= point_d;
			ended_q <= ended_d;
			nz_q <= nz_d;
			south_q <= south_d;
			west_q <= west_d;
			dir_q <= dir_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	ngga_to_e7 u_lat (
		.clk (clk),
		.en  (adv),
		.x   (x_lat),
		.neg (south_q),
		.e7  (lat_e7)
	);

	ngga_to_e7 u_lon (
		.clk (clk),
		.en  (adv),
		.x   (x_lon),
		.neg (west_q),
		.e7  (lon_e7)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_vld_q <= '0;
			conv_ok_q <= '0;
			out_valid_q <= 1'b0;
			stored_valid_q <= 1'b0;
			stored_lat_q <= '0;
			stored_lon_q <= '0;
		end else if (adv) begin
			conv_vld_q <= {conv_vld_q[CONV_LAT-2:0], launch};
			conv_ok_q <= {conv_ok_q[CONV_LAT-2:0], nz_q == 4'hF};
			out_valid_q <= conv_vld_q[CONV_LAT-1];
			if (conv_vld_q[CONV_LAT-1]) begin
				if (conv_ok_q[CONV_LAT-1]) begin
					stored_valid_q <= 1'b1;
					stored_lat_q <= lat_e7;
					stored_lon_q <= lon_e7;
				end else begin
					stored_valid_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign fix_valid = stored_valid_q;
	assign latitude_e7 = stored_lat_q;
	assign longitude_e7 = stored_lon_q;

endmodule
